>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define MI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define MI_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/mi_pkg.sv
package mi_pkg;

    // beat field width and default datapath width
    localparam int DATA_W    = 32;
    localparam int DEF_WIDTH = 32;

    // input beat
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] modulus;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [DATA_W-1:0] inverse;
        logic              status;
    } t_out_beat;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ALIGN,
        ST_SUB,
        ST_FIX,
        ST_WRAP,
        ST_DONE
    } t_state;

    // datapath operations
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_START,
        OP_ALIGN,
        OP_SUB,
        OP_FIX,
        OP_WRAP
    } t_op;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic r1_zero;
        logic mod_zero;
        logic can_shift;
        logic k_zero;
    } t_dp_flags;

endpackage

>>> src/mi_datapath.sv
module mi_datapath import mi_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic              i_clk,
    input  t_op               i_op,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_modulus,
    output t_dp_flags         o_flags,
    output logic [DATA_W-1:0] o_inverse,
    output logic              o_status
);

    localparam int KW = $clog2(WIDTH);

    // remainder chain and coefficient registers
    logic [WIDTH-1:0]        r_r0, n_r0, r_r1, n_r1;
    logic [WIDTH-1:0]        r_d, n_d, r_rem, n_rem, r_mod, n_mod;
    logic signed [WIDTH:0]   r_t0, n_t0, r_t1, n_t1, r_e, n_e, r_tacc, n_tacc;
    logic [KW-1:0]           r_k, n_k;
    logic                    r_fail, n_fail;

    // shared subtract and compare unit
    logic [WIDTH:0]          s_a, s_b;
    logic [WIDTH+1:0]        s_diff;
    logic                    s_ge;

    // coefficient lane
    logic signed [WIDTH:0]   t_sub, t_add, tacc_new;
    logic [WIDTH-1:0]        rem_new;

    // operand selection for the shared unit
    always_comb begin
        case (i_op)
            OP_ALIGN: begin
                s_a = {1'b0, r_rem};
                s_b = {r_d, 1'b0};
            end
            OP_WRAP: begin
                s_a = $unsigned(r_t0);
                s_b = {1'b0, r_mod};
            end
            default: begin
                s_a = {1'b0, r_rem};
                s_b = {1'b0, r_d};
            end
        endcase
    end

    assign s_diff = {1'b0, s_a} - {1'b0, s_b};
    assign s_ge   = ~s_diff[WIDTH+1];

    assign t_sub    = r_tacc - r_e;
    assign t_add    = r_t0 + $signed({1'b0, r_mod});
    assign rem_new  = s_ge ? s_diff[WIDTH-1:0] : r_rem;
    assign tacc_new = s_ge ? t_sub : r_tacc;

    // flags for the sequencer
    assign o_flags.r1_zero   = (r_r1 == '0);
    assign o_flags.mod_zero  = (r_mod == '0);
    assign o_flags.can_shift = ~r_d[WIDTH-1] & s_ge;
    assign o_flags.k_zero    = (r_k == '0);

    // next state of the datapath
    always_comb begin
        n_r0   = r_r0;
        n_r1   = r_r1;
        n_d    = r_d;
        n_rem  = r_rem;
        n_mod  = r_mod;
        n_t0   = r_t0;
        n_t1   = r_t1;
        n_e    = r_e;
        n_tacc = r_tacc;
        n_k    = r_k;
        n_fail = r_fail;
        case (i_op)
            OP_LOAD: begin
                n_r0  = WIDTH'(i_modulus);
                n_mod = WIDTH'(i_modulus);
                n_r1  = WIDTH'(i_value);
                n_t0  = '0;
                n_t1  = (WIDTH+1)'(1);
            end
            OP_START: begin
                n_d    = r_r1;
                n_e    = r_t1;
                n_rem  = r_r0;
                n_tacc = r_t0;
                n_k    = '0;
            end
            OP_ALIGN: begin
                // scale divisor and coefficient up while the divisor still fits
                if (o_flags.can_shift) begin
                    n_d = {r_d[WIDTH-2:0], 1'b0};
                    n_e = r_e <<< 1;
                    n_k = r_k + KW'(1);
                end
            end
            OP_SUB: begin
                // one quotient bit, then step the chain on the last bit
                if (o_flags.k_zero) begin
                    n_r0 = r_r1;
                    n_r1 = rem_new;
                    n_t0 = r_t1;
                    n_t1 = tacc_new;
                end else begin
                    n_rem  = rem_new;
                    n_tacc = tacc_new;
                    n_d    = r_d >> 1;
                    n_e    = r_e >>> 1;
                    n_k    = r_k - KW'(1);
                end
            end
            OP_FIX: begin
                n_fail = (r_r0 != WIDTH'(1));
                if (r_t0[WIDTH]) begin
                    n_t0 = t_add;
                end
            end
            OP_WRAP: begin
                if (s_ge) begin
                    n_t0 = $signed(s_diff[WIDTH:0]);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_d    <= n_d;
        r_rem  <= n_rem;
        r_mod  <= n_mod;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_e    <= n_e;
        r_tacc <= n_tacc;
        r_k    <= n_k;
        r_fail <= n_fail;
    end

    // result fields
    assign o_status  = r_fail;
    assign o_inverse = r_fail ? '0 : DATA_W'(r_t0[WIDTH-1:0]);

endmodule

>>> src/mi_ctrl.sv
module mi_ctrl import mi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_out_free,
    input  t_dp_flags i_flags,
    output t_op       o_op,
    output logic      o_busy,
    output logic      o_done
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath operation
    always_comb begin
        n_state = r_state;
        o_op    = OP_HOLD;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LOAD;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_flags.r1_zero || i_flags.mod_zero) begin
                    n_state = ST_FIX;
                end else begin
                    o_op    = OP_START;
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                o_op = OP_ALIGN;
                if (!i_flags.can_shift) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                o_op = OP_SUB;
                if (i_flags.k_zero) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FIX: begin
                o_op    = OP_FIX;
                n_state = ST_WRAP;
            end
            ST_WRAP: begin
                o_op    = OP_WRAP;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> src/modular_inverse_unit.sv
// modular inverse by the extended euclidean algorithm, one item at a time
// the unit takes no new item until the last one is through; the shared subtract/compare unit
// sets the pace; the output register lets a new item start while the last result waits
// reset (synchronous, active low) clears the sequencer and the output valid only
module modular_inverse_unit import mi_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    t_op               op;
    t_dp_flags         flags;
    logic              busy, done, start, out_free;
    logic [DATA_W-1:0] res_inverse;
    logic              res_status;

    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out_data, n_out_data;

    assign start    = i_valid & ~busy;
    assign out_free = ~r_out_valid | ~i_stall;

    mi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_op       (op),
        .o_busy     (busy),
        .o_done     (done)
    );

    mi_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_op      (op),
        .i_value   (i_data.value),
        .i_modulus (i_data.modulus),
        .o_flags   (flags),
        .o_inverse (res_inverse),
        .o_status  (res_status)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (done) begin
            n_out_valid        = 1'b1;
            n_out_data.inverse = res_inverse;
            n_out_data.status  = res_status;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_stall = busy;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

>>> src/mi_checker.sv
`include "assert_macros.svh"

module mi_checker import mi_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_beat o_data
);

    // a stalled result beat holds
    `MI_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_data), "out beat changed")

    // no inverse always reports zero
    `MI_ASSERT(a_fail_zero, o_valid && o_data.status |-> o_data.inverse == '0, "bad fail beat")

    // an accepted beat makes the unit busy
    `MI_ASSERT(a_busy_after, i_valid && !o_stall |=> o_stall, "not busy after accept")

    // a result only appears at the end of a busy period
    `MI_ASSERT(a_rise_busy, $rose(o_valid) |-> $past(o_stall), "result without work")

    // reset leaves the unit idle and empty
    `MI_ASSERT_RST(a_reset, !i_rst_n |=> !o_valid && !o_stall, "not idle after reset")

endmodule

bind modular_inverse_unit mi_checker u_mi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
